// ===== hdl/mvmc_pkg.sv =====
package mvmc_pkg;

   // Field widths
   localparam int unsigned OP_W    = 2;
   localparam int unsigned COORD_W = 64;
   localparam int unsigned IDX_W   = 16;
   localparam int unsigned CNT_W   = IDX_W + 1;
   localparam int unsigned ENTRY_W = IDX_W + 1;

   // Vertex capacity, limited to the remap memory depth
   localparam int unsigned MAX_VERTICES = 65536;
   localparam int unsigned TABLE_DEPTH  = 1 << IDX_W;
   localparam int unsigned CAP_INT      =
      (MAX_VERTICES < TABLE_DEPTH) ? MAX_VERTICES : TABLE_DEPTH;
   localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(CAP_INT);

   // Remap entry for a removed vertex: all ones
   localparam logic [ENTRY_W-1:0] REMOVED_MARK = '1;

   // Operation codes
   localparam logic [OP_W-1:0] OP_VERTEX   = 2'd0;
   localparam logic [OP_W-1:0] OP_TRIANGLE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

   // Result kinds
   localparam logic KIND_VERTEX   = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic               keep;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
      logic [IDX_W-1:0]   corner_a;
      logic [IDX_W-1:0]   corner_b;
      logic [IDX_W-1:0]   corner_c;
   } req_type;

   typedef struct packed {
      logic               item_kind;
      logic               capacity_error;
      logic [IDX_W-1:0]   new_vertex_index;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic [COORD_W-1:0] out_z;
      logic [IDX_W-1:0]   new_corner_a;
      logic [IDX_W-1:0]   new_corner_b;
      logic [IDX_W-1:0]   new_corner_c;
   } rsp_type;

endpackage

// ===== hdl/mvmc_ram.sv =====
module mvmc_ram #(
   parameter int unsigned ADDR_W = 16,
   parameter int unsigned DATA_W = 17
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int unsigned DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mvmc_rsp_reg.sv =====
module mvmc_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  mvmc_pkg::rsp_type push_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mvmc_pkg::rsp_type rsp_item
);

   import mvmc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type item_ff;
   rsp_type item_in;

   // Load when empty or when the held item leaves this cycle
   assign push_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push_valid && push_ready) begin
         valid_in = 1'b1;
         item_in  = push_item;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// ===== hdl/mvmc_ctrl.sv =====
module mvmc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mvmc_pkg::req_type             req_item,
   output logic                          wr_en,
   output logic [mvmc_pkg::IDX_W-1:0]    wr_addr,
   output logic [mvmc_pkg::ENTRY_W-1:0]  wr_data,
   output logic                          rd_en,
   output logic [mvmc_pkg::IDX_W-1:0]    rd_addr,
   input  logic [mvmc_pkg::ENTRY_W-1:0]  rd_data,
   output logic                          push_valid,
   input  logic                          push_ready,
   output mvmc_pkg::rsp_type             push_item
);

   import mvmc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK_A,
      ST_LOOK_B,
      ST_LOOK_C,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic [CNT_W-1:0] kept_ff, kept_in;
   logic             ok_ff, ok_in;
   logic [IDX_W-1:0] corner_a_ff, corner_a_in;
   logic [IDX_W-1:0] corner_b_ff, corner_b_in;
   logic [IDX_W-1:0] corner_c_ff, corner_c_in;
   rsp_type          pend_ff, pend_in;
   logic [IDX_W-1:0] look_idx;
   logic             corner_ok;

   // Pick the corner whose entry is on the read data this cycle
   always_comb begin
      case (state_ff)
         ST_LOOK_B: look_idx = corner_b_ff;
         ST_LOOK_C: look_idx = corner_c_ff;
         default:   look_idx = corner_a_ff;
      endcase
   end

   // A corner survives if already seen and not removed
   assign corner_ok = ({1'b0, look_idx} < seen_ff) && (rd_data != REMOVED_MARK);

   always_comb begin
      state_in    = state_ff;
      seen_in     = seen_ff;
      kept_in     = kept_ff;
      ok_in       = ok_ff;
      corner_a_in = corner_a_ff;
      corner_b_in = corner_b_ff;
      corner_c_in = corner_c_ff;
      pend_in     = pend_ff;
      req_ready   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = seen_ff[IDX_W-1:0];
      wr_data     = REMOVED_MARK;
      rd_en       = 1'b0;
      rd_addr     = corner_b_ff;
      push_valid  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_item.operation)
                  OP_VERTEX: begin
                     pend_in           = '0;
                     pend_in.item_kind = KIND_VERTEX;
                     if (seen_ff >= CAPACITY) begin
                        // Drop the vertex and report overflow
                        pend_in.capacity_error = 1'b1;
                        state_in               = ST_EMIT;
                     end else begin
                        wr_en   = 1'b1;
                        seen_in = seen_ff + 1'b1;
                        if (req_item.keep) begin
                           wr_data                  = {1'b0, kept_ff[IDX_W-1:0]};
                           pend_in.new_vertex_index = kept_ff[IDX_W-1:0];
                           pend_in.out_x            = req_item.coord_x;
                           pend_in.out_y            = req_item.coord_y;
                           pend_in.out_z            = req_item.coord_z;
                           kept_in                  = kept_ff + 1'b1;
                           state_in                 = ST_EMIT;
                        end
                     end
                  end
                  OP_TRIANGLE: begin
                     // Start the corner lookups
                     rd_en             = 1'b1;
                     rd_addr           = req_item.corner_a;
                     corner_a_in       = req_item.corner_a;
                     corner_b_in       = req_item.corner_b;
                     corner_c_in       = req_item.corner_c;
                     ok_in             = 1'b1;
                     pend_in           = '0;
                     pend_in.item_kind = KIND_TRIANGLE;
                     state_in          = ST_LOOK_A;
                  end
                  OP_CLEAR: begin
                     seen_in = '0;
                     kept_in = '0;
                  end
                  OP_UNUSED: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOOK_A: begin
            ok_in                = ok_ff && corner_ok;
            pend_in.new_corner_a = rd_data[IDX_W-1:0];
            rd_en                = 1'b1;
            rd_addr              = corner_b_ff;
            state_in             = ST_LOOK_B;
         end
         ST_LOOK_B: begin
            ok_in                = ok_ff && corner_ok;
            pend_in.new_corner_b = rd_data[IDX_W-1:0];
            rd_en                = 1'b1;
            rd_addr              = corner_c_ff;
            state_in             = ST_LOOK_C;
         end
         ST_LOOK_C: begin
            ok_in                = ok_ff && corner_ok;
            pend_in.new_corner_c = rd_data[IDX_W-1:0];
            state_in             = (ok_ff && corner_ok) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            // Hold until the output register takes the item
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= '0;
         kept_ff  <= '0;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
         kept_ff  <= kept_in;
         ok_ff    <= ok_in;
      end
      corner_a_ff <= corner_a_in;
      corner_b_ff <= corner_b_in;
      corner_c_ff <= corner_c_in;
      pend_ff     <= pend_in;
   end

   assign push_item = pend_ff;

`ifndef SYNTHESIS
   a_kept_le_seen: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= seen_ff)
      else $error("kept count exceeds seen count");

   a_seen_le_cap: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CAPACITY)
      else $error("seen count exceeds capacity");

   a_clear_counts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_item.operation == OP_CLEAR)
      |=> (seen_ff == '0) && (kept_ff == '0))
      else $error("clear did not reset the counters");

   a_tri_no_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && (pend_ff.item_kind == KIND_TRIANGLE)
      |-> !pend_ff.capacity_error)
      else $error("triangle result flagged as capacity error");

   a_full_rejects: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_item.operation == OP_VERTEX)
      && (seen_ff >= CAPACITY) |=> $stable(seen_ff) && pend_ff.capacity_error)
      else $error("overflow vertex changed state or lost its error flag");
`endif

endmodule

// ===== hdl/mesh_vertex_mask_compactor.sv =====
// Mesh vertex mask compactor.
// Request channel (req_valid/req_ready/req_item) takes vertex, triangle and clear
// items in stream order; result channel (rsp_valid/rsp_ready/rsp_item) returns at
// most one item for each request. A kept vertex gets the next compacted index and
// leaves with its coordinates; a removed vertex and a clear leave nothing. A
// triangle leaves with remapped corners, or is dropped when a corner is removed
// or not yet seen. A vertex beyond capacity leaves an item flagged capacity_error.
// Steps per item: clear, removed vertex and unused code are done in the idle
// state; a vertex with a result adds the emit step; a triangle adds lookup
// steps for corners A, B and C, plus the emit step when it produces a result.
// The lookups follow the remap memory's single read port: the three corner
// entries are read one per cycle through its registered read data.
// A result reaches rsp_valid through the emit step and then the output register.
// Reset clears the vertex counters and the output register; the remap memory is
// not cleared, since only entries already written in the current mesh are used.
// When the receiver stalls, the result waits in the output register while the
// next item is taken and worked on; that item then holds in its emit step until
// the register frees up, and req_ready stays low meanwhile.
module mesh_vertex_mask_compactor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mvmc_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mvmc_pkg::rsp_type rsp_item
);

   import mvmc_pkg::*;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic               push_valid;
   logic               push_ready;
   rsp_type            push_item;

   // Sequencer and vertex counters
   mvmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Remap table
   mvmc_ram #(
      .ADDR_W (IDX_W),
      .DATA_W (ENTRY_W)
   ) u_remap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register
   mvmc_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule
